// ----- hdl/mba_pkg.sv -----
// Shared types and constants for the mouse button edge and acceleration block.
package mba_pkg;

   localparam int BTN_W       = 3;
   localparam int DELTA_W     = 8;
   localparam int CFG_W       = 8;
   localparam int MOVE_W      = 16;
   localparam int DIVIDEND_W  = 15;
   localparam int DIVISOR_W   = CFG_W;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUMERATOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DENOMINATOR = 2'd2;

   localparam logic [CFG_W-1:0] THRESHOLD_RST   = 8'd4;
   localparam logic [CFG_W-1:0] NUMERATOR_RST   = 8'd2;
   localparam logic [CFG_W-1:0] DENOMINATOR_RST = 8'd1;

   localparam logic [BTN_W-1:0] BTN_LEFT   = 3'b001;
   localparam logic [BTN_W-1:0] BTN_MIDDLE = 3'b010;
   localparam logic [BTN_W-1:0] BTN_RIGHT  = 3'b100;

   localparam logic [1:0] BTN_NUM_NONE   = 2'd0;
   localparam logic [1:0] BTN_NUM_LEFT   = 2'd1;
   localparam logic [1:0] BTN_NUM_MIDDLE = 2'd2;
   localparam logic [1:0] BTN_NUM_RIGHT  = 2'd3;

   localparam logic KIND_BUTTON = 1'b0;
   localparam logic KIND_MOTION = 1'b1;

   typedef struct packed {
      logic [BTN_W-1:0]   buttons;
      logic [BTN_W-1:0]   changed;
      logic               neg_x;
      logic [DELTA_W-1:0] mag_x;
      logic               neg_y;
      logic [DELTA_W-1:0] mag_y;
   } job_type;

   typedef struct packed {
      logic [CFG_W-1:0] threshold;
      logic [CFG_W-1:0] numerator;
      logic [CFG_W-1:0] denominator;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BTN,
      ST_START,
      ST_WAIT,
      ST_MOTION
   } back_state_type;

endpackage

// ----- hdl/mba_front.sv -----
// Front end: accepts reports, finds changed buttons and splits deltas into sign and magnitude.
module mba_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [mba_pkg::BTN_W-1:0]      button_bits,
   input  logic signed [mba_pkg::DELTA_W-1:0] delta_x,
   input  logic signed [mba_pkg::DELTA_W-1:0] delta_y,
   output logic                           push,
   output mba_pkg::job_type               job,
   input  logic                           queue_full
);

   logic [mba_pkg::BTN_W-1:0] prev_ff;
   logic [mba_pkg::BTN_W-1:0] prev_in;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   always_comb begin
      job.buttons = button_bits;
      job.changed = button_bits ^ prev_ff;
      job.neg_x   = delta_x[mba_pkg::DELTA_W-1];
      job.mag_x   = delta_x[mba_pkg::DELTA_W-1] ? (~delta_x + 8'd1) : delta_x;
      job.neg_y   = delta_y[mba_pkg::DELTA_W-1];
      job.mag_y   = delta_y[mba_pkg::DELTA_W-1] ? (~delta_y + 8'd1) : delta_y;
      prev_in     = push ? button_bits : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ----- hdl/mba_fifo.sv -----
// Short queue of classified reports between the front and back ends.
module mba_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mba_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output mba_pkg::job_type pop_data
);

   mba_pkg::job_type                 mem_ff [mba_pkg::QUEUE_DEPTH];
   logic [mba_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [mba_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [mba_pkg::QCNT_W-1:0]       count_ff;
   logic [mba_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [mba_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [mba_pkg::QCNT_W-1:0]       count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == mba_pkg::QCNT_W'(mba_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mba_pkg::QPTR_W'(mba_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mba_pkg::QPTR_W'(mba_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + mba_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - mba_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/mba_div.sv -----
// Restoring divider, one quotient bit per cycle.
module mba_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mba_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [mba_pkg::DIVISOR_W-1:0]      divisor,
   output logic                               done,
   output logic [mba_pkg::DIVIDEND_W-1:0]     quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [mba_pkg::DIV_CNT_W-1:0]       count_ff;
   logic [mba_pkg::DIVISOR_W-1:0]       rem_ff;
   logic [mba_pkg::DIVIDEND_W-1:0]      quo_ff;
   logic [mba_pkg::DIVISOR_W-1:0]       dvs_ff;
   logic [mba_pkg::DIVISOR_W:0]         trial;
   logic [mba_pkg::DIVISOR_W:0]         diff;
   logic                                fits;
   logic [mba_pkg::DIVISOR_W-1:0]       rem_in;
   logic [mba_pkg::DIVIDEND_W-1:0]      quo_in;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial  = {rem_ff, quo_ff[mba_pkg::DIVIDEND_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? diff[mba_pkg::DIVISOR_W-1:0] : trial[mba_pkg::DIVISOR_W-1:0];
      quo_in = {quo_ff[mba_pkg::DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + mba_pkg::DIV_CNT_W'(1);
         if (count_ff == mba_pkg::DIV_CNT_W'(mba_pkg::DIVIDEND_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

endmodule

// ----- hdl/mba_back.sv -----
// Back end: emits button results, then scales both deltas and emits the motion result.
module mba_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mba_pkg::cfg_type                     cfg,
   input  logic                                 job_valid,
   input  mba_pkg::job_type                     job,
   output logic                                 job_pop,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic                                 out_kind,
   output logic [1:0]                           out_button_number,
   output logic                                 out_pressed,
   output logic signed [mba_pkg::MOVE_W-1:0]    out_move_x,
   output logic signed [mba_pkg::MOVE_W-1:0]    out_move_y,
   output logic                                 out_last
);

   mba_pkg::back_state_type              state_ff;
   mba_pkg::back_state_type              state_in;
   mba_pkg::job_type                     job_ff;
   logic [mba_pkg::BTN_W-1:0]            pending_ff;
   logic                                 axis_ff;
   logic [mba_pkg::MOVE_W-1:0]           move_x_ff;
   logic [mba_pkg::MOVE_W-1:0]           move_y_ff;
   logic                                 rsp_valid_ff;
   logic                                 rsp_kind_ff;
   logic [1:0]                           rsp_num_ff;
   logic                                 rsp_pressed_ff;
   logic [mba_pkg::MOVE_W-1:0]           rsp_mx_ff;
   logic [mba_pkg::MOVE_W-1:0]           rsp_my_ff;
   logic                                 rsp_last_ff;

   logic                                 out_free;
   logic                                 emit_btn;
   logic                                 emit_motion;
   logic                                 div_start;
   logic                                 div_done;
   logic [mba_pkg::DIVIDEND_W-1:0]       div_quo;
   logic [mba_pkg::BTN_W-1:0]            btn_mask;
   logic [1:0]                           btn_num;
   logic                                 btn_pressed;
   logic [mba_pkg::DELTA_W-1:0]          mag_sel;
   logic                                 neg_sel;
   logic                                 scaled;
   logic [mba_pkg::DELTA_W-1:0]          excess;
   logic [2*mba_pkg::CFG_W-1:0]          product;
   logic [mba_pkg::DIVIDEND_W-1:0]       dividend;
   logic [mba_pkg::DIVISOR_W-1:0]        divisor;
   logic [mba_pkg::DIVIDEND_W-1:0]       res_abs;
   logic [mba_pkg::MOVE_W-1:0]           res_ext;
   logic [mba_pkg::MOVE_W-1:0]           res_signed;

   assign out_free = !rsp_valid_ff || out_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mba_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = mba_pkg::ST_BTN;
            end
         end
         mba_pkg::ST_BTN: begin
            if (pending_ff == '0) begin
               state_in = mba_pkg::ST_START;
            end
         end
         mba_pkg::ST_START: begin
            state_in = mba_pkg::ST_WAIT;
         end
         mba_pkg::ST_WAIT: begin
            if (div_done) begin
               state_in = axis_ff ? mba_pkg::ST_MOTION : mba_pkg::ST_START;
            end
         end
         mba_pkg::ST_MOTION: begin
            if (out_free) begin
               state_in = mba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mba_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      job_pop     = 1'b0;
      emit_btn    = 1'b0;
      emit_motion = 1'b0;
      div_start   = 1'b0;
      case (state_ff)
         mba_pkg::ST_IDLE:   job_pop     = job_valid;
         mba_pkg::ST_BTN:    emit_btn    = (pending_ff != '0) && out_free;
         mba_pkg::ST_START:  div_start   = 1'b1;
         mba_pkg::ST_MOTION: emit_motion = out_free;
         default: begin
         end
      endcase
   end

   // lowest pending button goes first
   always_comb begin
      btn_mask = '0;
      btn_num  = mba_pkg::BTN_NUM_NONE;
      if ((pending_ff & mba_pkg::BTN_LEFT) != '0) begin
         btn_mask = mba_pkg::BTN_LEFT;
         btn_num  = mba_pkg::BTN_NUM_LEFT;
      end else if ((pending_ff & mba_pkg::BTN_MIDDLE) != '0) begin
         btn_mask = mba_pkg::BTN_MIDDLE;
         btn_num  = mba_pkg::BTN_NUM_MIDDLE;
      end else if ((pending_ff & mba_pkg::BTN_RIGHT) != '0) begin
         btn_mask = mba_pkg::BTN_RIGHT;
         btn_num  = mba_pkg::BTN_NUM_RIGHT;
      end
      btn_pressed = ((job_ff.buttons & btn_mask) != '0);
   end

   always_comb begin
      mag_sel    = axis_ff ? job_ff.mag_y : job_ff.mag_x;
      neg_sel    = axis_ff ? job_ff.neg_y : job_ff.neg_x;
      scaled     = (mag_sel > cfg.threshold);
      excess     = mag_sel - cfg.threshold;
      product    = {{mba_pkg::CFG_W{1'b0}}, excess} * {{mba_pkg::CFG_W{1'b0}}, cfg.numerator};
      dividend   = scaled ? product[mba_pkg::DIVIDEND_W-1:0] : '0;
      divisor    = (cfg.denominator == '0) ? mba_pkg::DIVISOR_W'(1) : cfg.denominator;
      res_abs    = scaled ? (mba_pkg::DIVIDEND_W'(cfg.threshold) + div_quo)
                          : mba_pkg::DIVIDEND_W'(mag_sel);
      res_ext    = {1'b0, res_abs};
      res_signed = neg_sel ? (~res_ext + 16'd1) : res_ext;
   end

   mba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff     <= job;
         pending_ff <= job.changed;
         axis_ff    <= 1'b0;
      end else begin
         if (emit_btn) begin
            pending_ff <= pending_ff & ~btn_mask;
         end
         if ((state_ff == mba_pkg::ST_WAIT) && div_done) begin
            if (axis_ff) begin
               move_y_ff <= res_signed;
            end else begin
               move_x_ff <= res_signed;
            end
            axis_ff <= ~axis_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_btn) begin
         rsp_kind_ff    <= mba_pkg::KIND_BUTTON;
         rsp_num_ff     <= btn_num;
         rsp_pressed_ff <= btn_pressed;
         rsp_mx_ff      <= '0;
         rsp_my_ff      <= '0;
         rsp_last_ff    <= 1'b0;
      end else if (emit_motion) begin
         rsp_kind_ff    <= mba_pkg::KIND_MOTION;
         rsp_num_ff     <= mba_pkg::BTN_NUM_NONE;
         rsp_pressed_ff <= 1'b0;
         rsp_mx_ff      <= move_x_ff;
         rsp_my_ff      <= move_y_ff;
         rsp_last_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_btn || emit_motion) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid         = rsp_valid_ff;
   assign out_kind          = rsp_kind_ff;
   assign out_button_number = rsp_num_ff;
   assign out_pressed       = rsp_pressed_ff;
   assign out_move_x        = rsp_mx_ff;
   assign out_move_y        = rsp_my_ff;
   assign out_last          = rsp_last_ff;

endmodule

// ----- hdl/mouse_button_edge_and_accel.sv -----
// Top level: mouse report button edge detection and threshold motion acceleration.
//
//   channel  ports                        payload (low bit first)
//   req      req_tvalid/tready/tdata      button_bits[2:0], delta_x[10:3], delta_y[18:11]
//   rsp      rsp_tvalid/tready/tdata/     button_number[1:0], pressed[2], move_x[18:3],
//            tuser/tlast                  move_y[34:19]; tuser event_kind; tlast last
//   csr      csr_valid/ready/index/data   index 0 threshold, 1 numerator, 2 denominator
//
// A report holds the back end while it pops the job, emits one item per changed
// button, ends the button scan, runs each axis in turn on the shared restoring
// divider (start, 15 steps, done) and emits the motion item.
// Synchronous active-high reset clears the previous button state, the queue and
// the control state, and loads the register defaults.
// Up to two reports wait in the queue; a stalled rsp holds its item in the output register.
module mouse_button_edge_and_accel (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mba_pkg::REQ_DATA_W-1:0]  req_tdata,  // button_bits, delta_x, delta_y
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mba_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // button_number, pressed, move_x, move_y
   output logic                            rsp_tuser,  // event_kind
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mba_pkg::CFG_W-1:0]       csr_data
);

   mba_pkg::cfg_type                        cfg_ff;
   mba_pkg::job_type                        front_job;
   mba_pkg::job_type                        queue_job;
   logic                                    front_push;
   logic                                    queue_full;
   logic                                    queue_valid;
   logic                                    back_pop;
   logic [1:0]                              button_number;
   logic                                    pressed;
   logic signed [mba_pkg::MOVE_W-1:0]       move_x;
   logic signed [mba_pkg::MOVE_W-1:0]       move_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= mba_pkg::THRESHOLD_RST;
         cfg_ff.numerator   <= mba_pkg::NUMERATOR_RST;
         cfg_ff.denominator <= mba_pkg::DENOMINATOR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mba_pkg::REG_THRESHOLD:   cfg_ff.threshold   <= csr_data;
            mba_pkg::REG_NUMERATOR:   cfg_ff.numerator   <= csr_data;
            mba_pkg::REG_DENOMINATOR: cfg_ff.denominator <= csr_data;
            default: begin
            end
         endcase
      end
   end

   mba_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .button_bits (req_tdata[2:0]),
      .delta_x     (req_tdata[10:3]),
      .delta_y     (req_tdata[18:11]),
      .push        (front_push),
      .job         (front_job),
      .queue_full  (queue_full)
   );

   mba_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_job),
      .full      (queue_full),
      .pop       (back_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_job)
   );

   mba_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .job_valid         (queue_valid),
      .job               (queue_job),
      .job_pop           (back_pop),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_kind          (rsp_tuser),
      .out_button_number (button_number),
      .out_pressed       (pressed),
      .out_move_x        (move_x),
      .out_move_y        (move_y),
      .out_last          (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, move_y, move_x, pressed, button_number};

   a_button_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mba_pkg::KIND_BUTTON) |->
         !rsp_tlast && (button_number != mba_pkg::BTN_NUM_NONE)
         && (move_x == '0) && (move_y == '0))
      else $error("button result malformed");

   a_motion_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mba_pkg::KIND_MOTION) |->
         rsp_tlast && (button_number == mba_pkg::BTN_NUM_NONE) && !pressed)
      else $error("motion result malformed");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> queue_valid)
      else $error("pop from empty queue");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !front_push)
      else $error("queue accepted while full");

endmodule
